// ===== hw/rtl/gsl_pkg.sv =====
package gsl_pkg;

	localparam int MAX_KEYS   = 64;
	localparam int KEY_BITS   = 32;
	localparam int LABEL_BITS = 6;
	localparam int ADDR_BITS  = $clog2(MAX_KEYS);
	localparam int CNT_BITS   = $clog2(MAX_KEYS + 1);

	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [LABEL_BITS-1:0] label;
	} gsl_entry_t;

	localparam int ENTRY_BITS = $bits(gsl_entry_t);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_START,
		ST_HOLD,
		ST_CMP,
		ST_PLACE,
		ST_OUT_RD,
		ST_OUT_WAIT,
		ST_OUT_SEND
	} gsl_state_t;

endpackage

// ===== hw/rtl/gsl_in_if.sv =====
interface gsl_in_if
	import gsl_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] key;
	logic                last;

	modport source (output valid, output key, output last, input ready);
	modport sink (input valid, input key, input last, output ready);
endinterface

// ===== hw/rtl/gsl_out_if.sv =====
interface gsl_out_if
	import gsl_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] sorted_key;
	logic [5:0]          origin_index;
	logic                final_res;
	logic                overflow;

	modport source (output valid, output sorted_key, output origin_index,
		output final_res, output overflow, input ready);
	modport sink (input valid, input sorted_key, input origin_index,
		input final_res, input overflow, output ready);
endinterface

// ===== hw/rtl/gsl_ram.sv =====
module gsl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/gnome_sort_with_labels.sv =====
// channel  dir  word fields                                        handshake
// item     in   key[31:0] signed Q16.16, last                      valid/ready
// result   out  sorted_key[31:0], origin_index[5:0], final_res,    valid/ready
//               overflow
//
// Loading accepts one word per cycle; words beyond MAX_KEYS are dropped and flagged.
// Sort: one compare/move per cycle through the key RAM (one read, one write port);
// key i passes ST_HOLD, then ST_CMP once per move, then a final ST_CMP write or, at the front, ST_PLACE.
// Output: each word goes through ST_OUT_WAIT (registered RAM read) and ST_OUT_SEND, held until ready.
// item.ready is high only while loading; arst_n clears all control state.
module gnome_sort_with_labels
	import gsl_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	gsl_in_if.sink   item,
	gsl_out_if.source result
);
	gsl_state_t state_q, state_d;

	logic [CNT_BITS-1:0]  cnt_q, cnt_d;
	logic                 drop_q, drop_d;
	logic [CNT_BITS-1:0]  n_q, n_d;
	logic [CNT_BITS-1:0]  i_q, i_d;
	logic [ADDR_BITS-1:0] h_q, h_d;
	logic [CNT_BITS-1:0]  k_q, k_d;
	gsl_entry_t           x_q;
	gsl_entry_t           res_q;
	logic                 fin_q;
	logic                 ovf_q;

	logic                 we;
	logic [ADDR_BITS-1:0] waddr;
	gsl_entry_t           wdata;
	logic [ADDR_BITS-1:0] raddr;
	gsl_entry_t           rdata;
	logic [CNT_BITS-1:0]  i_nx;
	logic [CNT_BITS-1:0]  cnt_nx;

	gsl_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (MAX_KEYS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign i_nx   = i_q + CNT_BITS'(1);
	assign cnt_nx = cnt_q + CNT_BITS'(1);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		drop_d  = drop_q;
		n_d     = n_q;
		i_d     = i_q;
		h_d     = h_q;
		k_d     = k_q;
		we      = 1'b0;
		waddr   = h_q;
		wdata   = x_q;
		raddr   = h_q;
		unique case (state_q)
			ST_LOAD: begin
				if (item.valid) begin
					if (cnt_q < CNT_BITS'(MAX_KEYS)) begin
						we          = 1'b1;
						waddr       = cnt_q[ADDR_BITS-1:0];
						wdata.key   = item.key;
						wdata.label = LABEL_BITS'(cnt_q);
						cnt_d       = cnt_nx;
					end else begin
						drop_d = 1'b1;
					end
					if (item.last) begin
						n_d = (cnt_q < CNT_BITS'(MAX_KEYS)) ? cnt_nx : cnt_q;
						k_d = '0;
						if (n_d == CNT_BITS'(1)) begin
							state_d = ST_OUT_RD;
						end else begin
							state_d = ST_START;
						end
					end
				end
			end
			ST_START: begin
				i_d     = CNT_BITS'(1);
				h_d     = ADDR_BITS'(1);
				raddr   = ADDR_BITS'(1);
				state_d = ST_HOLD;
			end
			ST_HOLD: begin
				raddr   = h_q - ADDR_BITS'(1);
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if ($signed(rdata.key) > $signed(x_q.key)) begin
					we    = 1'b1;
					waddr = h_q;
					wdata = rdata;
					h_d   = h_q - ADDR_BITS'(1);
					raddr = h_q - ADDR_BITS'(2);
					if (h_q == ADDR_BITS'(1)) begin
						state_d = ST_PLACE;
					end
				end else begin
					we = 1'b1;
					if (i_nx == n_q) begin
						k_d     = '0;
						state_d = ST_OUT_RD;
					end else begin
						i_d     = i_nx;
						h_d     = i_nx[ADDR_BITS-1:0];
						raddr   = i_nx[ADDR_BITS-1:0];
						state_d = ST_HOLD;
					end
				end
			end
			ST_PLACE: begin
				we = 1'b1;
				if (i_nx == n_q) begin
					k_d     = '0;
					state_d = ST_OUT_RD;
				end else begin
					i_d     = i_nx;
					h_d     = i_nx[ADDR_BITS-1:0];
					raddr   = i_nx[ADDR_BITS-1:0];
					state_d = ST_HOLD;
				end
			end
			ST_OUT_RD: begin
				raddr   = k_q[ADDR_BITS-1:0];
				state_d = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				state_d = ST_OUT_SEND;
			end
			ST_OUT_SEND: begin
				if (result.ready) begin
					if (fin_q) begin
						cnt_d   = '0;
						drop_d  = 1'b0;
						state_d = ST_LOAD;
					end else begin
						k_d     = k_q + CNT_BITS'(1);
						raddr   = k_d[ADDR_BITS-1:0];
						state_d = ST_OUT_WAIT;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			n_q     <= '0;
			i_q     <= '0;
			h_q     <= '0;
			k_q     <= '0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			drop_q  <= drop_d;
			n_q     <= n_d;
			i_q     <= i_d;
			h_q     <= h_d;
			k_q     <= k_d;
			if (state_q == ST_OUT_WAIT) begin
				fin_q <= (k_q + CNT_BITS'(1)) == n_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD) begin
			x_q <= rdata;
		end
		if (state_q == ST_OUT_WAIT) begin
			res_q <= rdata;
			ovf_q <= drop_q;
		end
	end

	assign item.ready          = (state_q == ST_LOAD);
	assign result.valid        = (state_q == ST_OUT_SEND);
	assign result.sorted_key   = res_q.key;
	assign result.origin_index = res_q.label;
	assign result.final_res    = fin_q;
	assign result.overflow     = ovf_q;

`ifndef NO_ASSERTIONS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(item.ready && result.valid))
		else $error("input and output sides active together");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(MAX_KEYS))
		else $error("load count beyond capacity");

	a_sort_write_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		(we && (state_q == ST_CMP || state_q == ST_PLACE)) |->
		(CNT_BITS'(waddr) < n_q))
		else $error("sort write outside loaded set");

	a_final_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && result.final_res) |=> item.ready)
		else $error("not back to loading after final word");
`endif
endmodule

// ===== tb/gnome_sort_with_labels_tb.sv =====
module gnome_sort_with_labels_tb;
	import gsl_pkg::*;

	localparam int WORD_TARGET = 270;
	localparam int STALL_LIMIT = 20000;
	localparam int LONG_HOLD   = 400;

	typedef struct {
		logic [KEY_BITS-1:0] key;
		logic                last;
		bit                  drain;
	} key_word_t;

	typedef struct {
		logic [KEY_BITS-1:0]   key;
		logic [LABEL_BITS-1:0] index;
		logic                  final_res;
		logic                  overflow;
	} sorted_word_t;

	logic clk;
	logic arst_n;

	gsl_in_if  item_if();
	gsl_out_if result_if();

	gnome_sort_with_labels dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	key_word_t    pending_words[$];
	sorted_word_t sorted_results_q[$];

	logic signed [KEY_BITS-1:0]   set_keys [MAX_KEYS];
	logic        [LABEL_BITS-1:0] set_labels [MAX_KEYS];
	int set_fill;
	bit set_dropped;

	int  error_count;
	int  results_checked;
	int  words_queued;
	int  sets_queued;
	int  truncated_sets;
	bit  word_taken;
	int  burst_left;
	int  gap_left;
	int  hold_left;
	bit  long_hold_done;
	int  rx_cycle;
	int  rx_mode;
	int  idle_cycles;

	initial begin
		clk = 1'b0;
	end

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// store the word with its arrival label; on last, gnome sort and queue the run
	task automatic argsort_collect(input logic [KEY_BITS-1:0] key, input logic last);
		logic signed [KEY_BITS-1:0]   tmp_key;
		logic        [LABEL_BITS-1:0] tmp_label;
		int pos;
		if (set_fill < MAX_KEYS) begin
			set_keys[set_fill] = key;
			set_labels[set_fill] = LABEL_BITS'(set_fill);
			set_fill++;
		end else begin
			set_dropped = 1'b1;
		end
		if (last) begin
			pos = 0;
			while (pos < set_fill) begin
				if (pos == 0 || set_keys[pos-1] <= set_keys[pos]) begin
					pos++;
				end else begin
					tmp_key = set_keys[pos];
					tmp_label = set_labels[pos];
					set_keys[pos] = set_keys[pos-1];
					set_labels[pos] = set_labels[pos-1];
					set_keys[pos-1] = tmp_key;
					set_labels[pos-1] = tmp_label;
					pos--;
				end
			end
			for (int i = 0; i < set_fill; i++)
				sorted_results_q.push_back('{set_keys[i], set_labels[i],
					i == set_fill - 1, set_dropped});
			set_fill = 0;
			set_dropped = 1'b0;
		end
	endtask

	task automatic queue_word(input logic [KEY_BITS-1:0] key, input logic last,
		input bit drain);
		pending_words.push_back('{key, last, drain});
		words_queued++;
		if (last)
			sets_queued++;
	endtask

	function automatic logic [KEY_BITS-1:0] random_key();
		logic [KEY_BITS-1:0] k;
		case ($urandom_range(0, 4))
			0: k = KEY_BITS'($signed($urandom_range(0, 6)) - 3);
			1: begin
				case ($urandom_range(0, 3))
					0: k = {1'b1, {(KEY_BITS-1){1'b0}}};
					1: k = {1'b0, {(KEY_BITS-1){1'b1}}};
					2: k = '1;
					default: k = '0;
				endcase
			end
			2: k = {16'($urandom_range(0, 65535)), 16'h0000};
			default: k = $urandom;
		endcase
		return k;
	endfunction

	initial begin : stimulus
		logic [KEY_BITS-1:0] edge_keys [10];
		int set_len;
		int set_no;
		bit drain;

		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.key = '0;
		item_if.last = 1'b0;
		result_if.ready = 1'b0;

		// single-key set at the negative extreme
		queue_word(32'h8000_0000, 1'b1, 1'b1);
		// extremes with duplicates to check stable order
		edge_keys = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h0000_0001, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0000,
			32'hFFFF_FFFF, 32'h7FFF_FFFF};
		foreach (edge_keys[i])
			queue_word(edge_keys[i], i == 9, 1'b0);
		// already ascending
		for (int i = 0; i < 5; i++)
			queue_word(KEY_BITS'(i - 2), i == 4, 1'b0);
		// descending with a tie
		edge_keys[0:4] = '{32'd4, 32'd3, 32'd3, 32'd1, -32'sd5};
		for (int i = 0; i < 5; i++)
			queue_word(edge_keys[i], i == 4, i == 0);

		set_no = 0;
		while (words_queued < WORD_TARGET) begin
			if (set_no == 2)
				set_len = MAX_KEYS;
			else if (set_no == 5)
				set_len = MAX_KEYS + $urandom_range(1, 3);
			else
				set_len = $urandom_range(1, 12);
			if (set_len > MAX_KEYS)
				truncated_sets++;
			drain = ($urandom_range(0, 4) == 0);
			for (int k = 0; k < set_len; k++)
				queue_word(random_key(), k == set_len - 1, drain && k == 0);
			set_no++;
		end

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || item_if.valid || sorted_results_q.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
		if (sorted_results_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $realtime, sorted_results_q.size());
			error_count++;
		end

		$display("Sorted %0d key words in %0d sets (%0d past capacity), %0d results checked.",
			words_queued, sets_queued, truncated_sets, results_checked);
		$display("Set sizes ran from one key to a full store, with input and output stalls.");
		if (error_count == 0)
			$display("gnome_sort_with_labels_tb OK");
		else
			$display("gnome_sort_with_labels_tb NOT OK");
		$finish;
	end

	always @(negedge clk) begin : driver
		logic nxt_valid;
		nxt_valid = item_if.valid;
		if (!arst_n) begin
			nxt_valid = 1'b0;
			burst_left <= 8;
			gap_left <= 0;
		end else if (!item_if.valid || word_taken) begin
			nxt_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_words.size() != 0 &&
				!(pending_words[0].drain && sorted_results_q.size() != 0)) begin
				item_if.key <= pending_words[0].key;
				item_if.last <= pending_words[0].last;
				nxt_valid = 1'b1;
				void'(pending_words.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
		item_if.valid <= nxt_valid;
	end

	always @(negedge clk) begin : receiver
		logic nxt_ready;
		if (!arst_n) begin
			nxt_ready = 1'b0;
		end else if (hold_left > 0) begin
			nxt_ready = 1'b0;
			hold_left <= hold_left - 1;
		end else if (!long_hold_done && result_if.valid && results_checked >= 20) begin
			nxt_ready = 1'b0;
			hold_left <= LONG_HOLD;
			long_hold_done <= 1'b1;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle % 128 == 0)
				rx_mode <= $urandom_range(0, 2);
			case (rx_mode)
				0: nxt_ready = 1'b1;
				1: nxt_ready = 1'($urandom_range(0, 1));
				default: nxt_ready = (rx_cycle % 8) < 2;
			endcase
		end
		result_if.ready <= nxt_ready;
	end

	always @(posedge clk) begin : monitor
		sorted_word_t got;
		sorted_word_t want;
		if (arst_n) begin
			word_taken <= item_if.valid && item_if.ready;
			if (item_if.valid && item_if.ready)
				argsort_collect(item_if.key, item_if.last);
			if (result_if.valid && result_if.ready) begin
				got = '{result_if.sorted_key, result_if.origin_index,
					result_if.final_res, result_if.overflow};
				results_checked++;
				if (sorted_results_q.size() == 0) begin
					error_count++;
					$display("%0t: unexpected word key %h index %0d final %0b overflow %0b",
						$realtime, got.key, got.index, got.final_res, got.overflow);
				end else begin
					want = sorted_results_q.pop_front();
					if (got.key !== want.key || got.index !== want.index ||
						got.final_res !== want.final_res || got.overflow !== want.overflow) begin
						error_count++;
						$display("%0t: expected key %h index %0d final %0b overflow %0b",
							$realtime, want.key, want.index, want.final_res, want.overflow);
						$display("%0t:      got key %h index %0d final %0b overflow %0b",
							$realtime, got.key, got.index, got.final_res, got.overflow);
					end
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (item_if.valid && item_if.ready) ||
			(result_if.valid && result_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $realtime, idle_cycles);
				$display("gnome_sort_with_labels_tb NOT OK");
				$finish;
			end
		end
	end

endmodule
